// File: rtl/core/rltm_pkg.sv
// shared types, constants and helpers of the redo log transaction manager
package rltm_pkg;

  localparam int BlockW   = 20;
  localparam int CountW   = 5;
  localparam int AreaW    = 11;
  localparam int BpoW     = 5;
  localparam int OpW      = 3;
  localparam int StatusW  = 3;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;
  localparam int NeedW    = 12;

  localparam int LogEntriesDef = 16;
  localparam int BlockBitsDef  = 20;

  localparam logic [BlockW-1:0] LogAreaStartRst = BlockW'(2);
  localparam logic [AreaW-1:0]  LogAreaBlocksRst = AreaW'(30);
  localparam logic [BpoW-1:0]   BlocksPerOpRst = BpoW'(10);

  typedef enum logic [OpW-1:0] {
    OP_BEGIN          = 3'd0,
    OP_END            = 3'd1,
    OP_LOG_WRITE      = 3'd2,
    OP_RECOVER_ENTRY  = 3'd3,
    OP_RECOVER_FINISH = 3'd4,
    OP_COMMIT_DONE    = 3'd5
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_WAIT     = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_CONFLICT = 3'd4
  } status_t;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE   = 2'd0,
    CMD_COPY   = 2'd1,
    CMD_HEADER = 2'd2
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOG_AREA_START  = 2'd0,
    REG_LOG_AREA_BLOCKS = 2'd1,
    REG_BLOCKS_PER_OP   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [BlockW-1:0] log_area_start;
    logic [AreaW-1:0]  log_area_blocks;
    logic [BpoW-1:0]   blocks_per_operation;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    cmd_t              command;
    logic [BlockW-1:0] source_block;
    logic [BlockW-1:0] destination_block;
    logic [CountW-1:0] header_count;
    logic              last;
  } rsp_t;

  function automatic rsp_t make_rsp(status_t st, cmd_t cmd, logic [BlockW-1:0] src,
                                    logic [BlockW-1:0] dst, logic [CountW-1:0] cnt,
                                    logic lst);
    rsp_t r;
    r.status            = st;
    r.command           = cmd;
    r.source_block      = src;
    r.destination_block = dst;
    r.header_count      = cnt;
    r.last              = lst;
    return r;
  endfunction

endpackage

// File: rtl/core/rltm_if.sv
// handshake channels: configuration writes, requests and results
interface rltm_cfg_if import rltm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface rltm_req_if import rltm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [BlockW-1:0] block_number;
  modport source (output valid, operation, block_number, input ready);
  modport sink (input valid, operation, block_number, output ready);
endinterface

interface rltm_rsp_if import rltm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CmdW-1:0]    command;
  logic [BlockW-1:0]  source_block;
  logic [BlockW-1:0]  destination_block;
  logic [CountW-1:0]  header_count;
  logic               last;
  modport source (output valid, status, command, source_block, destination_block,
                  header_count, last, input ready);
  modport sink (input valid, status, command, source_block, destination_block,
                header_count, last, output ready);
endinterface

// File: rtl/core/rltm_cfg_regs.sv
// configuration registers of the redo log transaction manager
module rltm_cfg_regs import rltm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rltm_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.log_area_start       <= LogAreaStartRst;
      regs.log_area_blocks      <= LogAreaBlocksRst;
      regs.blocks_per_operation <= BlocksPerOpRst;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_LOG_AREA_START:  regs.log_area_start <= cfg.data[BlockW-1:0];
        REG_LOG_AREA_BLOCKS: regs.log_area_blocks <= cfg.data[AreaW-1:0];
        REG_BLOCKS_PER_OP:   regs.blocks_per_operation <= cfg.data[BpoW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/rltm_table.sv
// table of logged home block numbers, one write and one registered read port
module rltm_table import rltm_pkg::*; #(
  parameter int LOG_ENTRIES = LogEntriesDef,
  localparam int IdxW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IdxW-1:0]   wr_addr,
  input  logic [BlockW-1:0] wr_data,
  input  logic [IdxW-1:0]   rd_addr,
  output logic [BlockW-1:0] rd_data
);

  logic [BlockW-1:0] mem [LOG_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/rltm_seq.sv
// sequencer with shared compare unit: admission, table search and commit walk
module rltm_seq import rltm_pkg::*; #(
  parameter int LOG_ENTRIES = LogEntriesDef,
  parameter int BLOCK_BITS  = BlockBitsDef,
  localparam int IdxW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  rltm_req_if.sink          req,
  rltm_rsp_if.source        rsp,
  output logic              wr_en,
  output logic [IdxW-1:0]   wr_addr,
  output logic [BlockW-1:0] wr_data,
  output logic [IdxW-1:0]   rd_addr,
  input  logic [BlockW-1:0] rd_data
);

  localparam logic [BlockW-1:0] BlkMask =
    (BLOCK_BITS >= BlockW) ? {BlockW{1'b1}} : BlockW'((64'(1) << BLOCK_BITS) - 64'(1));

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_COPY_IN, S_HDR_N, S_INSTALL, S_HDR_Z
  } state_t;

  state_t            state, state_next;
  logic [CountW-1:0] idx, idx_next;
  logic [CountW-1:0] count, count_next;
  logic [CountW-1:0] open, open_next;
  logic              busy, busy_next;
  logic [BlockW-1:0] blk, blk_next;
  logic              rsp_valid, rsp_valid_next;
  rsp_t              res, res_next;

  logic              out_free;
  logic              accept;
  logic [BlockW-1:0] blk_in;
  logic [BlockW-1:0] head;
  logic [BlockW-1:0] slot;
  logic              too_big;
  logic [NeedW-1:0]  need;
  logic              begin_wait;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign blk_in    = req.block_number & BlkMask;
  assign head      = cfg.log_area_start & BlkMask;
  assign slot      = (cfg.log_area_start + BlockW'(idx) + BlockW'(1)) & BlkMask;
  assign too_big   = (count >= CountW'(LOG_ENTRIES)) ||
                     ((AreaW'(count) + AreaW'(1)) >= cfg.log_area_blocks);
  assign need      = NeedW'(count) +
                     (NeedW'(open) + NeedW'(1)) * NeedW'(cfg.blocks_per_operation);
  assign begin_wait = busy || (need > NeedW'(LOG_ENTRIES)) || (&open);

  assign rd_addr = idx_next[IdxW-1:0];
  assign wr_addr = count[IdxW-1:0];
  assign wr_data = (state == S_IDLE) ? blk_in : blk;

  assign rsp.valid             = rsp_valid;
  assign rsp.status            = res.status;
  assign rsp.command           = res.command;
  assign rsp.source_block      = res.source_block;
  assign rsp.destination_block = res.destination_block;
  assign rsp.header_count      = res.header_count;
  assign rsp.last              = res.last;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    count_next     = count;
    open_next      = open;
    busy_next      = busy;
    blk_next       = blk;
    rsp_valid_next = rsp_valid && !rsp.ready;
    res_next       = res;
    wr_en          = 1'b0;

    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (accept) begin
          rsp_valid_next = 1'b1;
          res_next = make_rsp(ST_OK, CMD_NONE, '0, '0, '0, 1'b1);
          case (op_t'(req.operation))
            OP_BEGIN: begin
              if (begin_wait) begin
                res_next.status = ST_WAIT;
              end else begin
                open_next = open + CountW'(1);
              end
            end
            OP_END: begin
              if (open == '0) begin
                res_next.status = ST_OUTSIDE;
              end else if (busy) begin
                res_next.status = ST_CONFLICT;
              end else begin
                open_next = open - CountW'(1);
                if (open == CountW'(1)) begin
                  busy_next = 1'b1;
                  if (count != '0) begin
                    rsp_valid_next = 1'b0;
                    state_next     = S_COPY_IN;
                  end
                end
              end
            end
            OP_LOG_WRITE: begin
              if (too_big) begin
                res_next.status = ST_TOO_BIG;
              end else if (open == '0) begin
                res_next.status = ST_OUTSIDE;
              end else begin
                rsp_valid_next = 1'b0;
                blk_next       = blk_in;
                state_next     = S_SEARCH;
              end
            end
            OP_RECOVER_ENTRY: begin
              if (open != '0 || busy) begin
                res_next.status = ST_CONFLICT;
              end else if (too_big) begin
                res_next.status = ST_TOO_BIG;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CountW'(1);
              end
            end
            OP_RECOVER_FINISH: begin
              if (open != '0 || busy) begin
                res_next.status = ST_CONFLICT;
              end else if (count == '0) begin
                res_next = make_rsp(ST_OK, CMD_HEADER, '0, head, '0, 1'b1);
              end else begin
                rsp_valid_next = 1'b0;
                state_next     = S_INSTALL;
              end
            end
            OP_COMMIT_DONE: begin
              busy_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (out_free) begin
          if (idx == count) begin
            wr_en          = 1'b1;
            count_next     = count + CountW'(1);
            rsp_valid_next = 1'b1;
            res_next       = make_rsp(ST_OK, CMD_NONE, '0, '0, '0, 1'b1);
            idx_next       = '0;
            state_next     = S_IDLE;
          end else if (rd_data == blk) begin
            rsp_valid_next = 1'b1;
            res_next       = make_rsp(ST_OK, CMD_NONE, '0, '0, '0, 1'b1);
            idx_next       = '0;
            state_next     = S_IDLE;
          end else begin
            idx_next = idx + CountW'(1);
          end
        end
      end
      S_COPY_IN: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          res_next = make_rsp(ST_OK, CMD_COPY, rd_data, slot, '0, 1'b0);
          if (idx == count - CountW'(1)) begin
            idx_next   = '0;
            state_next = S_HDR_N;
          end else begin
            idx_next = idx + CountW'(1);
          end
        end
      end
      S_HDR_N: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          res_next   = make_rsp(ST_OK, CMD_HEADER, '0, head, count, 1'b0);
          state_next = S_INSTALL;
        end
      end
      S_INSTALL: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          res_next = make_rsp(ST_OK, CMD_COPY, slot, rd_data, '0, 1'b0);
          if (idx == count - CountW'(1)) begin
            idx_next   = '0;
            state_next = S_HDR_Z;
          end else begin
            idx_next = idx + CountW'(1);
          end
        end
      end
      S_HDR_Z: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          res_next   = make_rsp(ST_OK, CMD_HEADER, '0, head, '0, 1'b1);
          count_next = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        idx_next   = '0;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      count     <= '0;
      open      <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      count     <= count_next;
      open      <= open_next;
      busy      <= busy_next;
      rsp_valid <= rsp_valid_next;
    end
    blk <= blk_next;
    res <= res_next;
  end

endmodule

// File: rtl/core/redo_log_transaction_manager.sv
// top level of the redo log transaction manager
// Takes one request at a time and answers through a result register. Begin, end
// without commit, recover entry, commit done and every rejected request give a
// single result. A log write compares the block against one table entry per
// cycle in a shared comparator. A commit walks the table through its single read
// port and emits one command per cycle while the sink takes them: 2 * entry_count
// + 2 results; a recover finish gives entry_count + 1 results the same way. A new
// request is taken once the walk is done and the result register is free.
module redo_log_transaction_manager import rltm_pkg::*; #(
  parameter int LOG_ENTRIES = LogEntriesDef,
  parameter int BLOCK_BITS  = BlockBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  rltm_cfg_if.sink    cfg,
  rltm_req_if.sink    req,
  rltm_rsp_if.source  rsp
);

  localparam int IdxW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

  cfg_t              regs;
  logic              tbl_wr_en;
  logic [IdxW-1:0]   tbl_wr_addr;
  logic [BlockW-1:0] tbl_wr_data;
  logic [IdxW-1:0]   tbl_rd_addr;
  logic [BlockW-1:0] tbl_rd_data;

  rltm_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rltm_table #(
    .LOG_ENTRIES (LOG_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  rltm_seq #(
    .LOG_ENTRIES (LOG_ENTRIES),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  a_status_only_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.command == CMD_NONE |-> rsp.last)
    else $error("result without command is not marked last");

  a_accept_needs_free_slot: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |-> !rsp.valid || rsp.ready)
    else $error("request taken while a result is stuck");

  a_table_write_in_range: assert property (@(posedge clk) disable iff (rst)
    tbl_wr_en |-> 32'(tbl_wr_addr) < LOG_ENTRIES)
    else $error("table write beyond its depth");

  a_commit_header_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.command == CMD_HEADER && rsp.header_count != '0 |-> !rsp.last)
    else $error("commit header closes the sequence");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the redo log transaction manager
module tb;
  import rltm_pkg::*;

  localparam int Entries = LogEntriesDef;
  localparam int MaxOpen = 31;
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;
  localparam int Phases = 8;
  localparam int ItemsPerPhase = 40;
  localparam int SettleCycles = 40;

  class commit_scoreboard;
    logic [BlockW-1:0] area_start;
    logic [AreaW-1:0]  area_blocks;
    logic [BpoW-1:0]   per_op;
    logic [BlockW-1:0] logged [Entries];
    int unsigned       entries;
    int unsigned       open_ops;
    bit                busy;
    rsp_t              commands_due[$];
    int                errors;

    function new();
      area_start  = LogAreaStartRst;
      area_blocks = LogAreaBlocksRst;
      per_op      = BlocksPerOpRst;
      foreach (logged[i]) logged[i] = '0;
      entries  = 0;
      open_ops = 0;
      busy     = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_LOG_AREA_START:  area_start = val[BlockW-1:0];
        REG_LOG_AREA_BLOCKS: area_blocks = val[AreaW-1:0];
        REG_BLOCKS_PER_OP:   per_op = val[BpoW-1:0];
        default: ;
      endcase
    endfunction

    function logic [BlockW-1:0] slot(int unsigned t);
      logic [BlockW-1:0] s;
      s = area_start + BlockW'(t + 1);
      return s;
    endfunction

    function void add(status_t st, cmd_t cmd, logic [BlockW-1:0] src,
                      logic [BlockW-1:0] dst, int unsigned cnt);
      rsp_t r;
      r.status            = st;
      r.command           = cmd;
      r.source_block      = src;
      r.destination_block = dst;
      r.header_count      = CountW'(cnt);
      r.last              = 1'b0;
      commands_due.push_back(r);
    endfunction

    // copy slots home, then clear the header
    function void install();
      for (int unsigned t = 0; t < entries; t++) add(ST_OK, CMD_COPY, slot(t), logged[t], 0);
      entries = 0;
      add(ST_OK, CMD_HEADER, '0, area_start, 0);
    endfunction

    function bit log_full();
      return entries >= Entries || entries + 1 >= area_blocks;
    endfunction

    function void note_request(logic [OpW-1:0] op, logic [BlockW-1:0] blk);
      int unsigned queued_n;
      int unsigned hit;
      status_t     st;
      rsp_t        tail;
      queued_n = commands_due.size();
      st = ST_OK;
      case (op)
        OP_BEGIN: begin
          if (busy || entries + (open_ops + 1) * per_op > Entries || open_ops >= MaxOpen)
            st = ST_WAIT;
          else
            open_ops++;
        end
        OP_END: begin
          if (open_ops == 0) begin
            st = ST_OUTSIDE;
          end else if (busy) begin
            st = ST_CONFLICT;
          end else begin
            open_ops--;
            if (open_ops == 0) begin
              busy = 1'b1;
              if (entries > 0) begin
                for (int unsigned i = 0; i < entries; i++)
                  add(ST_OK, CMD_COPY, logged[i], slot(i), 0);
                add(ST_OK, CMD_HEADER, '0, area_start, entries);
                install();
              end
            end
          end
        end
        OP_LOG_WRITE: begin
          if (log_full()) begin
            st = ST_TOO_BIG;
          end else if (open_ops == 0) begin
            st = ST_OUTSIDE;
          end else begin
            hit = 0;
            while (hit < entries && logged[hit] != blk) hit++;
            if (hit == entries) begin
              logged[entries] = blk;
              entries++;
            end
          end
        end
        OP_RECOVER_ENTRY: begin
          if (open_ops != 0 || busy) begin
            st = ST_CONFLICT;
          end else if (log_full()) begin
            st = ST_TOO_BIG;
          end else begin
            logged[entries] = blk;
            entries++;
          end
        end
        OP_RECOVER_FINISH: begin
          if (open_ops != 0 || busy) st = ST_CONFLICT;
          else install();
        end
        OP_COMMIT_DONE: busy = 1'b0;
        default: ;
      endcase
      if (commands_due.size() == queued_n) add(st, CMD_NONE, '0, '0, 0);
      tail = commands_due.pop_back();
      tail.last = 1'b1;
      commands_due.push_back(tail);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (commands_due.size() == 0) begin
        $error("result transfer with nothing pending: status %0d command %0d",
               got.status, got.command);
        errors++;
        return;
      end
      want = commands_due.pop_front();
      check_field("status", want.status, got.status);
      check_field("command", want.command, got.command);
      check_field("source_block", want.source_block, got.source_block);
      check_field("destination_block", want.destination_block, got.destination_block);
      check_field("header_count", want.header_count, got.header_count);
      check_field("last", want.last, got.last);
    endfunction

    function int pending();
      return commands_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rltm_cfg_if cfg_ch ();
  rltm_req_if req_ch ();
  rltm_rsp_if rsp_ch ();

  redo_log_transaction_manager dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  commit_scoreboard  books;
  int                sent;
  int                send_idle_pct;
  int                recv_stall_pct;
  logic [CfgDataW-1:0] start_tab [Phases];
  int                blocks_tab [Phases] = '{30, 1024, 5, 0, 2, 17, 12, 30};
  int                per_op_tab [Phases] = '{10, 1, 16, 4, 2, 3, 8, 10};

  always #4 clk = ~clk;

  always @(posedge clk) begin
    rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status            = status_t'(rsp_ch.status);
      got.command           = cmd_t'(rsp_ch.command);
      got.source_block      = rsp_ch.source_block;
      got.destination_block = rsp_ch.destination_block;
      got.header_count      = rsp_ch.header_count;
      got.last              = rsp_ch.last;
      books.check_result(got);
    end
    rsp_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [BlockW-1:0] rand_block();
    return BlockW'($urandom());
  endfunction

  task automatic send_req(logic [OpW-1:0] op, logic [BlockW-1:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.block_number <= blk;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    books.note_request(op, blk);
    sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    books.write_reg(idx, val);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (books.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_burst();
    int unsigned       pick;
    int unsigned       n;
    logic [BlockW-1:0] base;
    pick = $urandom_range(99);
    base = rand_block();
    if (books.busy && $urandom_range(9) != 0) send_req(OP_COMMIT_DONE, rand_block());
    if (pick < 55) begin
      n = $urandom_range(1, 3);
      repeat (n) send_req(OP_BEGIN, rand_block());
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(10, 18);
        repeat (n) send_req(OP_LOG_WRITE, rand_block());
      end else begin
        n = $urandom_range(0, 6);
        repeat (n)
          send_req(OP_LOG_WRITE, ($urandom_range(9) < 7) ?
                   base + BlockW'($urandom_range(3)) : rand_block());
      end
      n = books.open_ops;
      if (n > 0 && $urandom_range(9) == 0) n--;
      repeat (n) send_req(OP_END, rand_block());
      if ($urandom_range(9) == 0) send_req(OP_END, rand_block());
      if ($urandom_range(9) != 0) send_req(OP_COMMIT_DONE, rand_block());
    end else if (pick < 75) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(10, 17) : $urandom_range(0, 6);
      repeat (n) send_req(OP_RECOVER_ENTRY, rand_block());
      send_req(OP_RECOVER_FINISH, rand_block());
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_req(OpW'($urandom_range(7)), rand_block());
    end
  endtask

  initial begin
    int target;
    books = new();
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    start_tab[0] = CfgDataW'(2);
    start_tab[1] = '0;
    start_tab[2] = '1;
    start_tab[3] = CfgDataW'(20'hFFFF0);
    start_tab[4] = CfgDataW'($urandom());
    start_tab[5] = CfgDataW'(20'h80000);
    start_tab[6] = CfgDataW'($urandom());
    start_tab[7] = CfgDataW'(2);
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LOG_AREA_START;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_BEGIN;
    req_ch.block_number = '0;
    rsp_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < Phases; p++) begin
      if (p > 0) begin
        write_reg(REG_LOG_AREA_START, start_tab[p]);
        write_reg(REG_LOG_AREA_BLOCKS, CfgDataW'(blocks_tab[p]));
        write_reg(REG_BLOCKS_PER_OP, CfgDataW'(per_op_tab[p]));
        cfg_ch.valid <= 1'b0;
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (p == 0) begin
        send_req(OP_END, '0);
        send_req(OP_LOG_WRITE, '1);
        send_req(OP_RECOVER_FINISH, '0);
        send_req(OP_COMMIT_DONE, '0);
        send_req(OpSpareLo, '1);
        send_req(OpSpareHi, '0);
        send_req(OP_BEGIN, '0);
        send_req(OP_BEGIN, '1);
        send_req(OP_LOG_WRITE, '1);
        send_req(OP_LOG_WRITE, '0);
        send_req(OP_LOG_WRITE, '1);
        send_req(OP_RECOVER_ENTRY, '1);
        send_req(OP_RECOVER_FINISH, '0);
        send_req(OP_END, '0);
        send_req(OP_BEGIN, '0);
        send_req(OP_RECOVER_ENTRY, '0);
        send_req(OP_COMMIT_DONE, '0);
        send_req(OP_RECOVER_ENTRY, 20'h5A5A5);
        send_req(OP_RECOVER_ENTRY, 20'hA5A5A);
        send_req(OP_RECOVER_FINISH, '0);
        send_req(OP_BEGIN, '0);
        send_req(OP_END, '0);
        send_req(OP_COMMIT_DONE, '0);
      end
      target = sent + ItemsPerPhase;
      while (sent < target) random_burst();
      drain();
    end

    if (books.errors == 0 && books.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #160_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
